### src/rk2a_pkg.sv
package rk2a_pkg;

    // Field widths
    localparam int unsigned KEY_W  = 8;
    localparam int unsigned CHAR_W = 7;

    // Keymap geometry
    localparam int unsigned KEYMAP_SIZE = 75;
    localparam int unsigned KEYMAP_IDX_W = $clog2(KEYMAP_SIZE);

    typedef logic [KEY_W-1:0]  t_keycode;
    typedef logic [CHAR_W-1:0] t_char;

    // Modifier press and release codes
    localparam t_keycode KC_SHIFT_L_DN = 8'd96;
    localparam t_keycode KC_SHIFT_R_DN = 8'd97;
    localparam t_keycode KC_CAPS_DN    = 8'd98;
    localparam t_keycode KC_CTRL_DN    = 8'd99;
    localparam t_keycode KC_SHIFT_L_UP = 8'd224;
    localparam t_keycode KC_SHIFT_R_UP = 8'd225;
    localparam t_keycode KC_CAPS_UP    = 8'd226;
    localparam t_keycode KC_CTRL_UP    = 8'd227;

    // Character constants
    localparam t_char CH_NONE   = 7'h00;
    localparam t_char CH_LOW_A  = 7'h61;
    localparam t_char CH_LOW_Z  = 7'h7A;
    localparam t_char CASE_DIFF = 7'h20;
    localparam t_char CTRL_DIFF = 7'h60;

    // Base keymap, indexed by key code
    localparam t_char KEYMAP [KEYMAP_SIZE] = '{
        7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
        7'h30, 7'h2D, 7'h3D,
        7'h5C, 7'h00, 7'h30, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75,
        7'h69, 7'h6F, 7'h70,
        7'h5B, 7'h5D, 7'h00, 7'h31, 7'h32, 7'h33, 7'h61, 7'h73, 7'h64, 7'h66,
        7'h67, 7'h68, 7'h6A,
        7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h00, 7'h00, 7'h34, 7'h35, 7'h36, 7'h00,
        7'h7A, 7'h78, 7'h63,
        7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2E, 7'h37,
        7'h38, 7'h39, 7'h20,
        7'h08, 7'h09, 7'h0D, 7'h0D, 7'h1B, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h2D
    };

    function automatic logic is_lower(input t_char c);
        return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    endfunction

    // Shifted symbol for punctuation and digit keys; others pass through
    function automatic t_char shifted_symbol(input t_char c);
        t_char s;
        case (c)
            7'h5B:   s = 7'h7B;
            7'h5D:   s = 7'h7D;
            7'h5C:   s = 7'h7C;
            7'h27:   s = 7'h22;
            7'h3B:   s = 7'h3A;
            7'h2F:   s = 7'h3F;
            7'h2E:   s = 7'h3E;
            7'h2C:   s = 7'h3C;
            7'h60:   s = 7'h7E;
            7'h3D:   s = 7'h2B;
            7'h2D:   s = 7'h5F;
            7'h31:   s = 7'h21;
            7'h32:   s = 7'h40;
            7'h33:   s = 7'h23;
            7'h34:   s = 7'h24;
            7'h35:   s = 7'h25;
            7'h36:   s = 7'h5E;
            7'h37:   s = 7'h26;
            7'h38:   s = 7'h2A;
            7'h39:   s = 7'h28;
            7'h30:   s = 7'h29;
            default: s = c;
        endcase
        return s;
    endfunction

endpackage

### src/rk2a_key_if.sv
interface rk2a_key_if;
    logic                valid;
    logic                ready;
    rk2a_pkg::t_keycode  keycode;

    modport source (output valid, output keycode, input ready);
    modport sink   (input valid, input keycode, output ready);
endinterface

### src/rk2a_char_if.sv
interface rk2a_char_if;
    logic             valid;
    logic             ready;
    rk2a_pkg::t_char  ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

### src/raw_keycode_to_ascii.sv
// Raw keyboard code to ASCII translator.
//
// i_key carries one raw 8-bit key code per word (bit 7 set on release);
// o_char returns exactly one 7-bit character per key word, 0 when the key
// gives no character (modifiers, releases, unmapped keys).
// Both channels move a word when valid and ready are high at a clock edge.
//
// The key word lands in an input register; the keymap lookup, modifier
// logic and flag update sit between that register and the result register.
// o_char.valid rises once the word moves from the input register into the result
// register. Throughput is one word per cycle while o_char.ready stays high;
// the path between the two registers is a single combinational pass.
// The input stage keeps taking words while a result waits, as long as it
// is empty or its word moves on in the same cycle.
//
// Reset (i_rst_n low, synchronous) empties both stages and clears the
// control, shift and caps lock flags. When the receiver holds o_char.ready
// low, the result holds, the input stage fills, then i_key.ready drops.
module raw_keycode_to_ascii (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rk2a_key_if.sink     i_key,
    rk2a_char_if.source  o_char
);

    logic                r_in_valid;
    rk2a_pkg::t_keycode  r_keycode;
    logic                r_out_valid;
    rk2a_pkg::t_char     r_ascii;

    logic                r_ctrl;
    logic                r_shift;
    logic                r_caps;
    logic                n_ctrl;
    logic                n_shift;
    logic                n_caps;
    logic                is_modifier;

    rk2a_pkg::t_char     base_char;
    rk2a_pkg::t_char     n_ascii;

    logic                out_adv;
    logic                in_adv;

    // Handshake chain
    assign out_adv     = r_in_valid && (!r_out_valid || o_char.ready);
    assign in_adv      = i_key.valid && i_key.ready;
    assign i_key.ready = !r_in_valid || out_adv;

    assign o_char.valid      = r_out_valid;
    assign o_char.ascii_char = r_ascii;

    // Modifier decode and flag update
    always_comb begin
        n_ctrl      = r_ctrl;
        n_shift     = r_shift;
        n_caps      = r_caps;
        is_modifier = 1'b1;
        unique case (r_keycode) inside
            rk2a_pkg::KC_CAPS_DN:  n_caps  = 1'b1;
            rk2a_pkg::KC_CAPS_UP:  n_caps  = 1'b0;
            rk2a_pkg::KC_CTRL_DN:  n_ctrl  = 1'b1;
            rk2a_pkg::KC_CTRL_UP:  n_ctrl  = 1'b0;
            rk2a_pkg::KC_SHIFT_L_DN, rk2a_pkg::KC_SHIFT_R_DN: n_shift = 1'b1;
            rk2a_pkg::KC_SHIFT_L_UP, rk2a_pkg::KC_SHIFT_R_UP: n_shift = 1'b0;
            default:               is_modifier = 1'b0;
        endcase
    end

    // Keymap lookup; codes past the table give no character
    always_comb begin
        base_char = rk2a_pkg::CH_NONE;
        if (!is_modifier && (r_keycode < rk2a_pkg::KEY_W'(rk2a_pkg::KEYMAP_SIZE))) begin
            base_char = rk2a_pkg::KEYMAP[r_keycode[rk2a_pkg::KEYMAP_IDX_W-1:0]];
        end
    end

    // Modifiers in priority order: control, shift, caps lock
    always_comb begin
        n_ascii = base_char;
        if (base_char != rk2a_pkg::CH_NONE) begin
            if (r_ctrl && rk2a_pkg::is_lower(base_char)) begin
                n_ascii = base_char - rk2a_pkg::CTRL_DIFF;
            end else if (r_shift) begin
                n_ascii = rk2a_pkg::is_lower(base_char) ?
                          (base_char - rk2a_pkg::CASE_DIFF) :
                          rk2a_pkg::shifted_symbol(base_char);
            end else if (r_caps && rk2a_pkg::is_lower(base_char)) begin
                n_ascii = base_char - rk2a_pkg::CASE_DIFF;
            end
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= 1'b1;
        end else if (out_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_keycode <= i_key.keycode;
        end
    end

    // Result stage and modifier flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ctrl      <= 1'b0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= 1'b1;
                r_ctrl      <= n_ctrl;
                r_shift     <= n_shift;
                r_caps      <= n_caps;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_ascii <= n_ascii;
        end
    end

endmodule
